>>> sv/json_string_unescape_unit_macros.svh
// Assertion macros used by the checker file of the string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/jsu_pkg.sv
// Types and constants shared by the string unescape unit.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESC,
    PH_HEX,
    PH_SBACK,
    PH_SU,
    PH_HEX2,
    PH_UTF8
  } phase_t;

  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
  } res_t;

  // Up to four results from one input byte; last_idx is the final slot.
  typedef struct packed {
    res_t [3:0] ent;
    logic [1:0] last_idx;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t b;
  } push_t;

endpackage
`default_nettype wire

>>> sv/jsu_decode.sv
// Decoder state and per-byte unescape logic; some bytes emit a result bundle.
`timescale 1ns / 1ps
`default_nettype none
module jsu_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_byte,
  input  wire logic          first,
  input  wire logic          no_more,
  output jsu_pkg::push_t     push
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CTRL_TOP = 8'd32;
  localparam logic [7:0] ASCII_TOP = 8'd128;
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_MAX    = 16'hDFFF;
  localparam logic [20:0] PLANE1      = 21'h10000;

  jsu_pkg::phase_t phase_r, phase_nxt, eff_phase;
  logic [15:0] hex_accum_r, hex_accum_nxt, eff_accum;
  logic [9:0]  high_unit_r, high_unit_nxt, eff_high;
  logic [1:0]  digit_count_r, digit_count_nxt, eff_digits;
  logic [23:0] utf8_hold_r, utf8_hold_nxt, eff_hold;
  logic [1:0]  utf8_needed_r, utf8_needed_nxt, eff_needed;

  logic        active, err, closed, emit;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic [1:0]  lead;
  logic [7:0]  cont_lo, cont_hi;
  logic [20:0] pair_cp;
  jsu_pkg::bundle_t bun;

  function automatic jsu_pkg::bundle_t one_res(input logic [7:0] d, input logic [1:0] st);
    jsu_pkg::bundle_t r;
    r = '0;
    r.ent[0].data   = d;
    r.ent[0].status = st;
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t utf8_enc(input logic [20:0] cp);
    jsu_pkg::bundle_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.ent[0].data = cp[7:0];
    end else if (cp < 21'h800) begin
      r.ent[0].data = {3'b110, cp[10:6]};
      r.ent[1].data = {2'b10, cp[5:0]};
      r.last_idx    = 2'd1;
    end else if (cp < 21'h10000) begin
      r.ent[0].data = {4'b1110, cp[15:12]};
      r.ent[1].data = {2'b10, cp[11:6]};
      r.ent[2].data = {2'b10, cp[5:0]};
      r.last_idx    = 2'd2;
    end else begin
      r.ent[0].data = {5'b11110, cp[20:18]};
      r.ent[1].data = {2'b10, cp[17:12]};
      r.ent[2].data = {2'b10, cp[11:6]};
      r.ent[3].data = {2'b10, cp[5:0]};
      r.last_idx    = 2'd3;
    end
    return r;
  endfunction

  // Bit 4 flags a valid hex digit, low bits give its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  always_comb begin
    // first restarts the decoder before the byte is taken
    eff_phase  = first ? jsu_pkg::PH_TEXT : phase_r;
    eff_accum  = first ? '0 : hex_accum_r;
    eff_high   = first ? '0 : high_unit_r;
    eff_digits = first ? '0 : digit_count_r;
    eff_hold   = first ? '0 : utf8_hold_r;
    eff_needed = first ? '0 : utf8_needed_r;
    active     = first || (phase_r != jsu_pkg::PH_IDLE);

    phase_nxt       = eff_phase;
    hex_accum_nxt   = eff_accum;
    high_unit_nxt   = eff_high;
    digit_count_nxt = eff_digits;
    utf8_hold_nxt   = eff_hold;
    utf8_needed_nxt = eff_needed;

    err     = 1'b0;
    closed  = 1'b0;
    emit    = 1'b0;
    bun     = '0;
    hv      = hex_val(in_byte);
    acc_new = {eff_accum[11:0], hv[3:0]};
    pair_cp = PLANE1 + {1'b0, eff_high, acc_new[9:0]};

    case (in_byte) inside
      [8'hC2:8'hDF]: lead = 2'd1;
      [8'hE0:8'hEF]: lead = 2'd2;
      [8'hF0:8'hF4]: lead = 2'd3;
      default:       lead = 2'd0;
    endcase

    cont_lo = 8'h80;
    cont_hi = 8'hBF;
    if (eff_hold[23:8] == 16'd0) begin
      case (eff_hold[7:0])
        8'hE0:   cont_lo = 8'hA0;
        8'hED:   cont_hi = 8'h9F;
        8'hF0:   cont_lo = 8'h90;
        8'hF4:   cont_hi = 8'h8F;
        default: ;
      endcase
    end

    case (eff_phase)
      jsu_pkg::PH_IDLE: ;
      jsu_pkg::PH_TEXT: begin
        if (in_byte == CH_QUOTE) begin
          closed = 1'b1;
        end else if (in_byte == CH_BSL) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else if (in_byte < CTRL_TOP) begin
          err = 1'b1;
        end else if (in_byte < ASCII_TOP) begin
          emit = 1'b1;
          bun  = one_res(in_byte, jsu_pkg::ST_DATA);
        end else if (lead == 2'd0) begin
          err = 1'b1;
        end else begin
          utf8_hold_nxt   = {16'd0, in_byte};
          utf8_needed_nxt = lead;
          phase_nxt       = jsu_pkg::PH_UTF8;
        end
      end
      jsu_pkg::PH_ESC: begin
        phase_nxt = jsu_pkg::PH_TEXT;
        emit      = 1'b1;
        case (in_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: bun = one_res(in_byte, jsu_pkg::ST_DATA);
          CH_B: bun = one_res(8'h08, jsu_pkg::ST_DATA);
          CH_F: bun = one_res(8'h0C, jsu_pkg::ST_DATA);
          CH_N: bun = one_res(8'h0A, jsu_pkg::ST_DATA);
          CH_R: bun = one_res(8'h0D, jsu_pkg::ST_DATA);
          CH_T: bun = one_res(8'h09, jsu_pkg::ST_DATA);
          CH_U: begin
            emit            = 1'b0;
            phase_nxt       = jsu_pkg::PH_HEX;
            hex_accum_nxt   = '0;
            digit_count_nxt = '0;
          end
          default: begin
            emit = 1'b0;
            err  = 1'b1;
          end
        endcase
      end
      jsu_pkg::PH_HEX, jsu_pkg::PH_HEX2: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else if (eff_digits != 2'd3) begin
          hex_accum_nxt   = acc_new;
          digit_count_nxt = eff_digits + 2'd1;
        end else begin
          // fourth digit completes the code unit
          hex_accum_nxt   = '0;
          digit_count_nxt = '0;
          if (eff_phase == jsu_pkg::PH_HEX) begin
            if (acc_new >= SURR_HI_MIN && acc_new <= SURR_MAX) begin
              if (acc_new >= SURR_LO_MIN) begin
                err = 1'b1;
              end else begin
                high_unit_nxt = acc_new[9:0];
                phase_nxt     = jsu_pkg::PH_SBACK;
              end
            end else begin
              emit      = 1'b1;
              bun       = utf8_enc({5'd0, acc_new});
              phase_nxt = jsu_pkg::PH_TEXT;
            end
          end else if (acc_new < SURR_LO_MIN || acc_new > SURR_MAX) begin
            err = 1'b1;
          end else begin
            emit      = 1'b1;
            bun       = utf8_enc(pair_cp);
            phase_nxt = jsu_pkg::PH_TEXT;
          end
        end
      end
      jsu_pkg::PH_SBACK: begin
        if (in_byte == CH_BSL) begin
          phase_nxt = jsu_pkg::PH_SU;
        end else begin
          err = 1'b1;
        end
      end
      jsu_pkg::PH_SU: begin
        if (in_byte == CH_U) begin
          phase_nxt       = jsu_pkg::PH_HEX2;
          hex_accum_nxt   = '0;
          digit_count_nxt = '0;
        end else begin
          err = 1'b1;
        end
      end
      jsu_pkg::PH_UTF8: begin
        if (in_byte < cont_lo || in_byte > cont_hi || eff_needed == 2'd0) begin
          err = 1'b1;
        end else if (eff_needed != 2'd1) begin
          utf8_needed_nxt = eff_needed - 2'd1;
          utf8_hold_nxt   = {eff_hold[15:0], in_byte};
        end else begin
          // sequence complete: flush held bytes then this one
          utf8_needed_nxt = '0;
          utf8_hold_nxt   = '0;
          phase_nxt       = jsu_pkg::PH_TEXT;
          emit            = 1'b1;
          if (eff_hold[23:16] != 8'd0) begin
            bun.ent[0].data = eff_hold[23:16];
            bun.ent[1].data = eff_hold[15:8];
            bun.ent[2].data = eff_hold[7:0];
            bun.ent[3].data = in_byte;
            bun.last_idx    = 2'd3;
          end else if (eff_hold[15:8] != 8'd0) begin
            bun.ent[0].data = eff_hold[15:8];
            bun.ent[1].data = eff_hold[7:0];
            bun.ent[2].data = in_byte;
            bun.last_idx    = 2'd2;
          end else begin
            bun.ent[0].data = eff_hold[7:0];
            bun.ent[1].data = in_byte;
            bun.last_idx    = 2'd1;
          end
        end
      end
      default: err = 1'b1;
    endcase

    if (active && !closed && no_more) begin
      err = 1'b1;
    end
    if (err || closed) begin
      emit            = 1'b1;
      bun             = one_res(8'd0, err ? jsu_pkg::ST_ERROR : jsu_pkg::ST_CLOSED);
      phase_nxt       = jsu_pkg::PH_IDLE;
      hex_accum_nxt   = '0;
      high_unit_nxt   = '0;
      digit_count_nxt = '0;
      utf8_hold_nxt   = '0;
      utf8_needed_nxt = '0;
    end
    if (!active) begin
      emit = 1'b0;
    end
  end

  assign push.valid = in_fire && emit;
  assign push.b     = bun;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= jsu_pkg::PH_IDLE;
      hex_accum_r   <= '0;
      high_unit_r   <= '0;
      digit_count_r <= '0;
      utf8_hold_r   <= '0;
      utf8_needed_r <= '0;
    end else if (in_fire && active) begin
      phase_r       <= phase_nxt;
      hex_accum_r   <= hex_accum_nxt;
      high_unit_r   <= high_unit_nxt;
      digit_count_r <= digit_count_nxt;
      utf8_hold_r   <= utf8_hold_nxt;
      utf8_needed_r <= utf8_needed_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/jsu_emit.sv
// Result register with skid slot; serializes each bundle one result per transfer.
`timescale 1ns / 1ps
`default_nettype none
module jsu_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  jsu_pkg::push_t     push,
  output logic               in_ready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  jsu_pkg::bundle_t cur_r, cur_nxt, skid_r, skid_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             at_last, cur_free;

  assign at_last  = (idx_r == cur_r.last_idx);
  assign cur_free = !cur_valid_r || (out_tready && at_last);

  always_comb begin
    cur_nxt        = cur_r;
    skid_nxt       = skid_r;
    cur_valid_nxt  = cur_valid_r;
    skid_valid_nxt = skid_valid_r;
    idx_nxt        = idx_r;
    if (cur_free) begin
      idx_nxt = '0;
      if (skid_valid_r) begin
        cur_nxt        = skid_r;
        cur_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push.valid) begin
        cur_nxt       = push.b;
        cur_valid_nxt = 1'b1;
      end else begin
        cur_valid_nxt = 1'b0;
      end
    end else begin
      if (out_tready) begin
        idx_nxt = idx_r + 2'd1;
      end
      // hold the new bundle while the current one drains
      if (push.valid) begin
        skid_nxt       = push.b;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      cur_valid_r  <= cur_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready   = !skid_valid_r;
  assign out_tvalid = cur_valid_r;
  assign out_tdata  = cur_r.ent[idx_r].data;
  assign out_tuser  = cur_r.ent[idx_r].status;
  assign out_tlast  = at_last;

endmodule
`default_nettype wire

>>> sv/json_string_unescape_unit.sv
// Top level of the JSON string body unescape unit.
//
//   channel  direction  tdata             tuser            tlast
//   in_      slave      [7:0] raw byte    [0] first        no_more
//   out_     master     [7:0] out byte    [1:0] status     last result of input
//
// One byte is accepted per cycle while in_tready is high; results are registered.
// A byte yielding k results occupies the output for k transfers (k up to 4);
// a skid slot lets one further byte enter while a bundle drains.
// in_tready drops only while the skid slot is full; output stalls hold everything.
// Reset (rst_n low, synchronous) returns the decoder to idle and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tuser,   // [0] first
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [1:0] status
  output logic            out_tlast
);

  jsu_pkg::push_t push;
  logic           in_fire;

  assign in_fire = in_tvalid && in_tready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .first   (in_tuser),
    .no_more (in_tlast),
    .push    (push)
  );

  jsu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> sv/jsu_checker.sv
// Port-level checks on the unescape unit and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_unit_macros.svh"
module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);

  logic end_res;

  assign end_res   = out_tvalid && (out_tuser == jsu_pkg::ST_CLOSED ||
                                    out_tuser == jsu_pkg::ST_ERROR);

  `JSU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output changed")
  `JSU_ASSERT_NOW(a_end_is_last, end_res, out_tlast, "close or error not final result of its byte")
  `JSU_ASSERT_NOW(a_end_zero, end_res, out_tdata == 8'd0, "close or error carries nonzero byte")
  `JSU_ASSERT_NOW(a_code_range, out_tvalid, out_tuser != 2'd3, "undefined status code")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (.*);
`default_nettype wire
